// ===== src/bmorph_pkg.sv =====
// Shared types and constants for the 3x3 binary erosion/dilation core.
// No dependencies; imported by bmorph_cfg_if, the core, bmorph_cell and the verification files.
`timescale 1ns / 1ps

package bmorph_pkg;

    // Default buffer sizing, overridable by the top-level parameters.
    localparam int DEF_MAX_COLUMN_LEN = 1024;
    localparam int DEF_MAX_COLUMNS    = 1024;

    // Width used for size comparisons; covers the largest legal maximum plus two.
    localparam int CNT_W = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_SIZE_W = 11;
    localparam int SIZE_RESET = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_DILATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH = 2'd2;

    // Input item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Per-cell control for the window chain.
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic       dilate;
        logic       row_en;
        logic [2:0] col_mask;
    } bmorph_cell_ctrl_t;

endpackage

// ===== src/bmorph_in_if.sv =====
// Input pixel channel: valid/ready handshake with op and pixel_set payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bmorph_in_if;
    logic valid;
    logic ready;
    logic op;
    logic pixel_set;

    modport source (output valid, output op, output pixel_set, input ready);
    modport sink   (input valid, input op, input pixel_set, output ready);
endinterface

// ===== src/bmorph_out_if.sv =====
// Result channel: valid/ready handshake with pixel_out and frame_last payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bmorph_out_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== src/bmorph_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on bmorph_pkg for the field widths.
`timescale 1ns / 1ps

interface bmorph_cfg_if
    import bmorph_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_SIZE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/binary_morphology_3x3_core.sv =====
// Streaming 3x3 binary erosion/dilation over a column-major frame.
// Depends on bmorph_pkg, the three channel interfaces, bmorph_linebuf and bmorph_cell.
//
//   channel   | dir | payload                  | transfer when
//   ----------+-----+--------------------------+-------------------
//   in_chan   | in  | op, pixel_set            | valid && ready
//   out_chan  | out | pixel_out, frame_last    | valid && ready
//   cfg       | in  | index, data              | valid && ready
//
// One item per cycle unless the output stalls. An item waits in the read stage for its line buffer
// row, then updates the window and loads the output register on the next transfer.
// The result for a pixel follows column_length + 1 items after it; a frame is
// W*L pixels plus L + 1 flush items. Reset needs no clearing pass: buffer rows are
// only used after they are written. Stalls on the output back up through the read
// stage; a new item is taken whenever the read stage empties on the same edge.
`timescale 1ns / 1ps

module binary_morphology_3x3_core
    import bmorph_pkg::*;
#(
    parameter int MAX_COLUMN_LEN = DEF_MAX_COLUMN_LEN,
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS
)(
    input  logic         clk,
    input  logic         rst_n,
    bmorph_in_if.sink    in_chan,
    bmorph_out_if.source out_chan,
    bmorph_cfg_if.sink   cfg
);

    localparam int ROW_W = (MAX_COLUMN_LEN > 1) ? $clog2(MAX_COLUMN_LEN) : 1;
    localparam int COL_W = $clog2(MAX_COLUMNS + 2);

    localparam logic [CNT_W-1:0] MAX_LEN_C  = CNT_W'(MAX_COLUMN_LEN);
    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLUMNS);
    localparam logic [CNT_W-1:0] RST_LEN    =
        (SIZE_RESET > MAX_COLUMN_LEN) ? MAX_LEN_C : CNT_W'(SIZE_RESET);
    localparam logic [CNT_W-1:0] RST_COLS   =
        (SIZE_RESET > MAX_COLUMNS) ? MAX_COLS_C : CNT_W'(SIZE_RESET);

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] raw,
                                                    input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] v;
        v = CNT_W'(raw);
        if (v == '0)
        begin
            return CNT_W'(1);
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return v;
    endfunction

    // Configuration.
    logic             mode_reg;
    logic [CNT_W-1:0] cols_reg;
    logic [CNT_W-1:0] len_reg;
    logic             cfg_write;
    logic             restart;

    // Frame position counters, kept at the accepting side.
    logic [ROW_W-1:0] irow_reg, irow_next;
    logic [COL_W-1:0] icol_reg, icol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;

    // Read stage.
    logic             a_valid_reg;
    logic             a_pix_reg;
    logic [ROW_W-1:0] a_addr_reg;
    logic             a_emit_reg;
    logic             a_last_reg;
    logic             a_top_reg;
    logic             a_bot_reg;
    logic             a_left_reg;
    logic             a_right_reg;

    // Output register.
    logic out_valid_reg;
    logic out_pixel_reg;
    logic out_last_reg;

    logic accept;
    logic a_leave;
    logic out_free;

    logic in_frame, emit, pix, row_wrap;
    logic top_ok, bot_ok, left_ok, right_ok, last;

    logic [1:0] buf_rd;
    logic [2:0] triple;
    logic [2:0] cell_din  [3];
    logic [2:0] cell_dout [3];
    logic [2:0] cell_flag;
    bmorph_cell_ctrl_t cell_ctrl [3];

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign restart   = cfg_write &&
                       (cfg.index == REG_COLUMN_COUNT || cfg.index == REG_COLUMN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            cols_reg <= RST_COLS;
            len_reg  <= RST_LEN;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_MODE_DILATE:   mode_reg <= cfg.data[0];
                REG_COLUMN_COUNT:  cols_reg <= clamp_size(cfg.data, MAX_COLS_C);
                REG_COLUMN_LENGTH: len_reg  <= clamp_size(cfg.data, MAX_LEN_C);
                default:           ;
            endcase
        end
    end

    assign out_free       = !out_valid_reg || out_chan.ready;
    assign a_leave        = a_valid_reg && (!a_emit_reg || out_free);
    assign in_chan.ready  = !a_valid_reg || a_leave;
    assign accept         = in_chan.valid && in_chan.ready;

    // Position bookkeeping for the item being taken: whether it yields a result, and
    // which neighbors of that result lie inside the frame.
    always_comb
    begin
        in_frame = CNT_W'(icol_reg) < cols_reg;
        emit     = (icol_reg >= COL_W'(2)) || (icol_reg == COL_W'(1) && irow_reg != '0);
        pix      = in_frame && (in_chan.op == OP_PIXEL) && in_chan.pixel_set;
        top_ok   = orow_reg != '0;
        bot_ok   = (CNT_W'(orow_reg) + CNT_W'(1)) < len_reg;
        left_ok  = ocol_reg != '0;
        right_ok = (CNT_W'(ocol_reg) + CNT_W'(1)) < cols_reg;
        last     = emit && !right_ok && !bot_ok;
        row_wrap = (CNT_W'(irow_reg) + CNT_W'(1)) >= len_reg;

        irow_next = row_wrap ? '0 : irow_reg + ROW_W'(1);
        icol_next = row_wrap ? icol_reg + COL_W'(1) : icol_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        if (emit)
        begin
            orow_next = bot_ok ? orow_reg + ROW_W'(1) : '0;
            ocol_next = bot_ok ? ocol_reg : ocol_reg + COL_W'(1);
        end
        if (last)
        begin
            irow_next = '0;
            icol_next = '0;
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irow_reg <= '0;
            icol_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
        end
        else if (restart)
        begin
            irow_reg <= '0;
            icol_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
        end
        else if (accept)
        begin
            irow_reg <= irow_next;
            icol_reg <= icol_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_leave)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg   <= pix;
            a_addr_reg  <= irow_reg;
            a_emit_reg  <= emit;
            a_last_reg  <= last;
            a_top_reg   <= top_ok;
            a_bot_reg   <= bot_ok;
            a_left_reg  <= left_ok;
            a_right_reg <= right_ok;
        end
    end

    // Entry layout: bit 1 is two columns back, bit 0 is the previous column.
    bmorph_linebuf #(
        .DEPTH (MAX_COLUMN_LEN)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (irow_reg),
        .wr_en   (a_leave),
        .wr_addr (a_addr_reg),
        .wr_data ({buf_rd[0], a_pix_reg}),
        .rd_data (buf_rd)
    );

    // Column order inside a triple: bit 0 left, bit 1 center, bit 2 right.
    assign triple = {a_pix_reg, buf_rd[0], buf_rd[1]};

    // Cell 2 takes the newest row, cell 1 the center row, cell 0 the row above.
    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_cell
            always_comb
            begin
                cell_ctrl[gi].shift    = a_leave;
                cell_ctrl[gi].clear    = restart || (a_leave && a_last_reg);
                cell_ctrl[gi].dilate   = mode_reg;
                cell_ctrl[gi].col_mask = {a_right_reg, 1'b1, a_left_reg};
                case (gi)
                    0:       cell_ctrl[gi].row_en = a_top_reg;
                    2:       cell_ctrl[gi].row_en = a_bot_reg;
                    default: cell_ctrl[gi].row_en = 1'b1;
                endcase
            end

            if (gi == 2)
            begin : g_head
                assign cell_din[gi] = triple;
            end
            else
            begin : g_body
                assign cell_din[gi] = cell_dout[gi + 1];
            end

            bmorph_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (cell_ctrl[gi]),
                .din   (cell_din[gi]),
                .dout  (cell_dout[gi]),
                .flag  (cell_flag[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_leave && a_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_leave && a_emit_reg)
        begin
            out_pixel_reg <= mode_reg ? (|cell_flag) : ~(|cell_flag);
            out_last_reg  <= a_last_reg;
        end
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.pixel_out  = out_pixel_reg;
    assign out_chan.frame_last = out_last_reg;

endmodule

// ===== src/bmorph_cell.sv =====
// One row slot of the 3x3 window: holds a three-column bit triple and passes it on.
// Depends on bmorph_pkg for the cell control struct.
`timescale 1ns / 1ps

module bmorph_cell
    import bmorph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bmorph_cell_ctrl_t ctrl,
    input  logic [2:0]        din,
    output logic [2:0]        dout,
    output logic              flag
);

    logic [2:0] bits_reg;
    logic [2:0] bits_next;

    // The flag looks at the triple being loaded, which is this slot's view of the
    // window for the pixel that leaves on the same transfer. In dilation it marks a
    // set neighbor, in erosion a clear one.
    always_comb
    begin
        bits_next = bits_reg;
        if (ctrl.clear)
        begin
            bits_next = '0;
        end
        else if (ctrl.shift)
        begin
            bits_next = din;
        end
        flag = ctrl.row_en & (|(ctrl.col_mask & (ctrl.dilate ? din : ~din)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    assign dout = bits_reg;

endmodule

// ===== src/bmorph_linebuf.sv =====
// Column line buffer: each entry holds the two earlier columns' bits of one row.
// Registered read with forwarding of a write to the same row on the same edge.
`timescale 1ns / 1ps

module bmorph_linebuf #(
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [1:0]        wr_data,
    output logic [1:0]        rd_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read that lands on the row being written in the same cycle gets the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

// ===== verif/morph_checker.sv =====
// Scoreboard for the 3x3 binary erosion/dilation core: watches the three channels,
// tracks the frame, window and column buffers on its own, and checks every result.
// Depends on bmorph_pkg and the channel interfaces.
`timescale 1ns / 1ps

module morph_checker
    import bmorph_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bmorph_in_if  in_chan,
    bmorph_out_if out_chan,
    bmorph_cfg_if cfg,
    output int    errors,
    output int    pending
);

    localparam int LEN_MAX   = DEF_MAX_COLUMN_LEN;
    localparam int COL_MAX   = DEF_MAX_COLUMNS;
    localparam int SHOWN_MAX = 40;

    typedef struct packed {
        logic pixel_out;
        logic frame_last;
    } morph_pixel_t;

    morph_pixel_t due_pixels [$];
    morph_pixel_t want;

    logic                  prev_col  [LEN_MAX];
    logic                  older_col [LEN_MAX];
    logic [8:0]            nbhd;
    int unsigned           in_col;
    int unsigned           in_row;
    int unsigned           out_col;
    int unsigned           out_row;
    logic                  dilate_q;
    logic [CFG_SIZE_W-1:0] cols_q;
    logic [CFG_SIZE_W-1:0] len_q;
    int                    shown;

    function automatic int unsigned size_in_use(logic [CFG_SIZE_W-1:0] v, int unsigned limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    task automatic restart_frame();
        nbhd    = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic report(input string what, input logic want_v, input logic got_v);
        if (shown < SHOWN_MAX)
        begin
            $display("%0t: mismatch on %s: expected %b, got %b", $realtime, what, want_v, got_v);
        end
        shown++;
        errors++;
    endtask

    // One accepted item: shift the column buffers and window, and queue the result
    // for the pixel one column plus one row behind, if there is one yet.
    task automatic absorb_item(input logic op_v, input logic pix_v);
        int unsigned  w;
        int unsigned  l;
        int unsigned  r;
        int           dr;
        int           dc;
        logic         pix;
        logic         p;
        logic         o;
        logic         emit;
        logic         bit_v;
        morph_pixel_t res;

        w    = size_in_use(cols_q, COL_MAX);
        l    = size_in_use(len_q, LEN_MAX);
        r    = in_row;
        emit = (in_col >= 2) || (in_col == 1 && r >= 1);
        pix  = (in_col < w && op_v == OP_PIXEL) ? pix_v : 1'b0;
        p    = 1'b0;
        o    = 1'b0;
        if (r < LEN_MAX)
        begin
            p            = prev_col[r];
            o            = older_col[r];
            older_col[r] = p;
            prev_col[r]  = pix;
        end
        // Each row slot holds {current, previous, older} columns, newest row on top.
        nbhd = {pix, p, o, nbhd[8:3]};

        in_row++;
        if (in_row >= l)
        begin
            in_row = 0;
            in_col++;
        end

        if (emit)
        begin
            res.pixel_out = !dilate_q;
            for (dr = -1; dr <= 1; dr++)
            begin
                for (dc = -1; dc <= 1; dc++)
                begin
                    if ((dr < 0 && out_row == 0) || (dr > 0 && out_row + 1 >= l) ||
                        (dc < 0 && out_col == 0) || (dc > 0 && out_col + 1 >= w))
                    begin
                        continue;
                    end
                    bit_v = nbhd[(1 + dr) * 3 + (1 + dc)];
                    if (dilate_q && bit_v)
                    begin
                        res.pixel_out = 1'b1;
                    end
                    if (!dilate_q && !bit_v)
                    begin
                        res.pixel_out = 1'b0;
                    end
                end
            end
            res.frame_last = (out_col + 1 >= w) && (out_row + 1 >= l);
            due_pixels.push_back(res);
            if (res.frame_last)
            begin
                restart_frame();
            end
            else
            begin
                out_row++;
                if (out_row >= l)
                begin
                    out_row = 0;
                    out_col++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEN_MAX; i++)
            begin
                prev_col[i]  = 1'b0;
                older_col[i] = 1'b0;
            end
            restart_frame();
            dilate_q = 1'b0;
            cols_q   = CFG_SIZE_W'(SIZE_RESET);
            len_q    = CFG_SIZE_W'(SIZE_RESET);
            due_pixels.delete();
            errors   = 0;
            shown    = 0;
            pending  = 0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (due_pixels.size() == 0)
                begin
                    report("result with none due", 1'bx, out_chan.pixel_out);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (out_chan.pixel_out !== want.pixel_out)
                    begin
                        report("pixel_out", want.pixel_out, out_chan.pixel_out);
                    end
                    if (out_chan.frame_last !== want.frame_last)
                    begin
                        report("frame_last", want.frame_last, out_chan.frame_last);
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE_DILATE:
                    begin
                        dilate_q = cfg.data[0];
                    end
                    REG_COLUMN_COUNT:
                    begin
                        cols_q = cfg.data;
                        restart_frame();
                    end
                    REG_COLUMN_LENGTH:
                    begin
                        len_q = cfg.data;
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_chan.valid && in_chan.ready)
            begin
                absorb_item(in_chan.op, in_chan.pixel_set);
            end
            pending = due_pixels.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench for binary_morphology_3x3_core: clock, reset, stimulus and verdict.
// Depends on bmorph_pkg, the channel interfaces, the core and morph_checker.
`timescale 1ns / 1ps

module testbench;
    import bmorph_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LARGE_ITEMS   = 1100;
    localparam int RANDOM_ITEMS  = 420;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk;
    logic rst_n;

    bmorph_in_if  in_chan ();
    bmorph_out_if out_chan ();
    bmorph_cfg_if cfg ();

    int                    mismatch_count;
    int                    due_count;
    idle_mode_t            idle_mode = IDLE_NONE;
    int                    hold_req = 0;
    int                    hold_ack = 0;
    int                    quiet_cycles = 0;
    logic [CFG_SIZE_W-1:0] cols_now = CFG_SIZE_W'(SIZE_RESET);
    logic [CFG_SIZE_W-1:0] len_now = CFG_SIZE_W'(SIZE_RESET);
    int                    frame_pos = 0;

    binary_morphology_3x3_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .cfg      (cfg)
    );

    morph_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .cfg      (cfg),
        .errors   (mismatch_count),
        .pending  (due_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
            (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("[binary_morphology_3x3_core] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls per phase, plus a long hold-off on request.
    initial
    begin
        int stall_pct;
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ack != hold_req)
            begin
                out_chan.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_ack = hold_req;
            end
            stall_pct = (idle_mode == IDLE_RECEIVER) ? 59 : (idle_mode == IDLE_BOTH) ? 12 : 0;
            out_chan.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int size_in_use(logic [CFG_SIZE_W-1:0] v, int limit);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    function automatic int frame_items();
        int l;
        l = size_in_use(len_now, DEF_MAX_COLUMN_LEN);
        return size_in_use(cols_now, DEF_MAX_COLUMNS) * l + l + 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_SIZE_W-1:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg.valid = 1'b0;
        case (idx)
            REG_COLUMN_COUNT:
            begin
                cols_now  = val;
                frame_pos = 0;
            end
            REG_COLUMN_LENGTH:
            begin
                len_now   = val;
                frame_pos = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Offers one item from a falling edge and returns at the falling edge after its transfer.
    task automatic push_item(input logic op_v, input logic pix_v);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 59 : (idle_mode == IDLE_BOTH) ? 12 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_chan.valid = 1'b0;
            @(negedge clk);
        end
        in_chan.valid     = 1'b1;
        in_chan.op        = op_v;
        in_chan.pixel_set = pix_v;
        @(posedge clk);
        while (!in_chan.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        frame_pos++;
        if (frame_pos >= frame_items())
        begin
            frame_pos = 0;
        end
    endtask

    // Mostly well-formed frames; a few flush ticks fall inside the pixel area and
    // some pixel items fall among the trailing flush ticks.
    task automatic send_stream(input int n, input int density);
        int   body;
        logic op_v;
        logic pix_v;
        for (int k = 0; k < n; k++)
        begin
            body  = frame_items() - size_in_use(len_now, DEF_MAX_COLUMN_LEN) - 1;
            pix_v = ($urandom_range(99) < density);
            if (frame_pos < body)
            begin
                op_v = ($urandom_range(99) < 3) ? OP_FLUSH : OP_PIXEL;
            end
            else
            begin
                op_v = ($urandom_range(99) < 20) ? OP_PIXEL : OP_FLUSH;
            end
            push_item(op_v, pix_v);
        end
    endtask

    // Waits until every due result has left, then lets the pipeline go quiet.
    task automatic settle();
        in_chan.valid = 1'b0;
        while (due_count != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_density();
        case ($urandom_range(2))
            0:       return 5;
            1:       return 50;
            default: return 95;
        endcase
    endfunction

    function automatic logic [CFG_SIZE_W-1:0] pick_size(input int top);
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_SIZE_W'(1);
            default: return CFG_SIZE_W'($urandom_range(2, top));
        endcase
    endfunction

    initial
    begin
        int                    phase;
        int                    n;
        int                    rand_items;
        logic [CFG_SIZE_W-1:0] w_pick;
        logic [CFG_SIZE_W-1:0] l_pick;

        rst_n             = 1'b0;
        in_chan.valid     = 1'b0;
        in_chan.op        = OP_PIXEL;
        in_chan.pixel_set = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = REG_MODE_DILATE;
        cfg.data          = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // 3x3 erosion: all ones but a flush tick in the top-left corner, and a
        // trailing section that mixes pixel items with flush ticks.
        write_reg(REG_UNUSED, 11'h7FF);
        write_reg(REG_MODE_DILATE, 11'h7FE);
        write_reg(REG_COLUMN_COUNT, 11'd3);
        write_reg(REG_COLUMN_LENGTH, 11'd3);
        for (n = 0; n < 9; n++)
        begin
            push_item((n == 0) ? OP_FLUSH : OP_PIXEL, 1'b1);
        end
        push_item(OP_PIXEL, 1'b1);
        push_item(OP_FLUSH, 1'b1);
        push_item(OP_FLUSH, 1'b0);
        push_item(OP_PIXEL, 1'b0);
        settle();

        // 3x3 dilation of a single set pixel in the bottom-right corner.
        write_reg(REG_MODE_DILATE, 11'h001);
        for (n = 0; n < 9; n++)
        begin
            push_item(OP_PIXEL, n == 8);
        end
        for (n = 0; n < 4; n++)
        begin
            push_item(OP_FLUSH, 1'b0);
        end
        settle();

        // Oversized sizes that clamp to the maximum: results start only after the
        // first full column. The receiver holds off early so that the core fills and
        // stalls its input. The frame is left unfinished; the next size write restarts it.
        idle_mode = IDLE_NONE;
        write_reg(REG_MODE_DILATE, 11'h400);
        write_reg(REG_COLUMN_COUNT, 11'h7FF);
        write_reg(REG_COLUMN_LENGTH, 11'h7FF);
        hold_req++;
        send_stream(LARGE_ITEMS, 90);
        settle();

        // Random phases with small frames. A phase may end mid-frame; the next one
        // then either rewrites a size, which restarts the frame, or only the mode.
        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            idle_mode = idle_mode_t'(phase % 4);
            write_reg(REG_MODE_DILATE, CFG_SIZE_W'($urandom_range(2047)));
            if (phase == 0 || $urandom_range(3) != 0)
            begin
                w_pick = pick_size(($urandom_range(4) == 0) ? 20 : 6);
                l_pick = pick_size(($urandom_range(4) == 0) ? 16 : 6);
                if ($urandom_range(1))
                begin
                    write_reg(REG_COLUMN_COUNT, w_pick);
                    write_reg(REG_COLUMN_LENGTH, l_pick);
                end
                else
                begin
                    write_reg(REG_COLUMN_LENGTH, l_pick);
                    write_reg(REG_COLUMN_COUNT, w_pick);
                end
                if ($urandom_range(7) == 0)
                begin
                    write_reg(REG_UNUSED, CFG_SIZE_W'($urandom_range(2047)));
                end
            end
            if ($urandom_range(2) == 0)
            begin
                n = $urandom_range(1, frame_items());
            end
            else
            begin
                n = frame_items() - frame_pos + $urandom_range(2) * frame_items();
            end
            if (n > RANDOM_ITEMS - rand_items)
            begin
                n = RANDOM_ITEMS - rand_items;
            end
            if (phase == 2 || phase == 6)
            begin
                hold_req++;
            end
            send_stream(n, pick_density());
            rand_items += n;
            settle();
            phase++;
        end

        if (mismatch_count == 0 && due_count == 0)
        begin
            $display("[binary_morphology_3x3_core] OK");
        end
        else
        begin
            $display("[binary_morphology_3x3_core] ERROR");
        end
        $finish;
    end

endmodule
